[src/eqc_pkg.sv]
// package: types, constants and tables for the equirect-to-cube coordinate block
`timescale 1ns / 1ps
`default_nettype none
package eqc_pkg;

   localparam int FRAC_BITS     = 8;
   localparam int MAX_FACE_SIZE = 4096;
   localparam int CORDIC_STEPS  = 16;
   localparam int SCALE_SHIFT   = 16;
   localparam int MAX_SRC       = 8192;

   localparam int CW = 34;
   localparam int ZW = 36;

   localparam logic signed [ZW-1:0] ANG_PI      = 36'sd2147483648;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 36'sd1073741824;
   localparam logic [30:0]          GAIN_Q30    = 31'd1768195363;
   localparam logic [20:0]          OUT_MAX     = 21'h1FFFFF;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   typedef enum logic [1:0] {
      CSR_FACE_SIZE     = 2'd0,
      CSR_SOURCE_WIDTH  = 2'd1,
      CSR_SOURCE_HEIGHT = 2'd2
   } csr_index_type;

   localparam int ST_IN      = 0;
   localparam int ST_CLAMP   = 1;
   localparam int ST_PREP    = 2;
   localparam int ST_C1      = 3;
   localparam int ST_MID     = ST_C1 + CORDIC_STEPS;
   localparam int ST_C2      = ST_MID + 1;
   localparam int ST_ANGLE   = ST_C2 + CORDIC_STEPS;
   localparam int ST_MUL     = ST_ANGLE + 1;
   localparam int ST_OUT     = ST_MUL + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [2:0]             face;
      logic [11:0]            row;
      logic [11:0]            col;
      logic signed [13:0]     px;
      logic signed [13:0]     py;
      logic signed [CW-1:0]   x;
      logic signed [CW-1:0]   y;
      logic signed [ZW-1:0]   z;
      logic signed [ZW-1:0]   u;
      logic                   ox_neg;
      logic                   ox_zero;
      logic                   oy_zero;
      logic                   oy_pos;
      logic                   top_seam;
      logic                   gneg;
      logic [28:0]            gm;
      logic [59:0]            gprod;
      logic signed [CW-1:0]   gy;
      logic [32:0]            tu;
      logic [31:0]            tv;
      logic [45:0]            xprod;
      logic [44:0]            yprod;
      logic [20:0]            sx;
      logic [20:0]            sy;
   } lane_type;

endpackage
`default_nettype wire

[src/equirect_to_cube_face_coords.sv]
// top level: pipelined cube face pixel to equirectangular source coordinate
//
// req_ channel: one word per cube face pixel (face index, row, column).
// rsp_ channel: one word per input word, source x and y in fixed point with
// eight fraction bits, in input order.
// csr_ channel: register writes (face size, source width, source height),
// always ready, to be written only while the pipeline is empty.
// datapath: two chained 16-step cordic vectoring units plus clamp, prep,
// angle and scaling stages.
// throughput: one word per cycle while the pipeline is not full and stalled, every stage holds a valid bit.
// a stalled rsp_ready holds the last stage; earlier stages keep filling
// empty slots, so req_ready drops only once the pipeline is full.
// reset clears all valid bits and loads face size 512, source 4096 x 2048.
`timescale 1ns / 1ps
`default_nettype none
module equirect_to_cube_face_coords (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_face_index,
   input  wire logic [11:0] req_pixel_row,
   input  wire logic [11:0] req_pixel_col,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [20:0]      rsp_source_x,
   output logic [20:0]      rsp_source_y,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data
);

   localparam int NS = eqc_pkg::NUM_STAGES;
   localparam int CW = eqc_pkg::CW;
   localparam int ZW = eqc_pkg::ZW;
   localparam int XS = 32 - eqc_pkg::FRAC_BITS;
   localparam int YS = 31 - eqc_pkg::FRAC_BITS;

   logic [12:0] face_size_ff;
   logic [13:0] source_width_ff;
   logic [13:0] source_height_ff;

   logic [12:0] n_cur;
   logic [12:0] w1_cur;
   logic [12:0] h1_cur;

   eqc_pkg::lane_type lane_ff [NS];
   eqc_pkg::lane_type lane_in [NS];
   logic [NS-1:0]     valid_ff;
   logic [NS-1:0]     valid_in;
   logic [NS-1:0]     adv;

   function automatic eqc_pkg::lane_type cordic_iter(eqc_pkg::lane_type a, logic [4:0] i);
      eqc_pkg::lane_type      r;
      logic signed [CW-1:0]   dx;
      logic signed [CW-1:0]   dy;
      logic signed [ZW-1:0]   at;
      r  = a;
      dx = a.y >>> i;
      dy = a.x >>> i;
      at = $signed(ZW'(eqc_pkg::ATAN_TURNS[i]));
      if (a.y > 0) begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + at;
      end else begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - at;
      end
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] fix_angle(eqc_pkg::lane_type a);
      logic signed [ZW-1:0] zz;
      zz = a.z;
      if (a.oy_zero) begin
         zz = a.ox_neg ? eqc_pkg::ANG_PI : '0;
      end else if (a.ox_zero) begin
         zz = a.oy_pos ? eqc_pkg::ANG_HALF_PI : -eqc_pkg::ANG_HALF_PI;
      end
      return zz;
   endfunction

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff     <= 13'd512;
         source_width_ff  <= 14'd4096;
         source_height_ff <= 14'd2048;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            eqc_pkg::CSR_FACE_SIZE:     face_size_ff     <= csr_data[12:0];
            eqc_pkg::CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data;
            eqc_pkg::CSR_SOURCE_HEIGHT: source_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (face_size_ff == '0) begin
         n_cur = 13'd1;
      end else if (face_size_ff > 13'(eqc_pkg::MAX_FACE_SIZE)) begin
         n_cur = 13'(eqc_pkg::MAX_FACE_SIZE);
      end else begin
         n_cur = face_size_ff;
      end
      if (source_width_ff == '0) begin
         w1_cur = '0;
      end else if (source_width_ff > 14'(eqc_pkg::MAX_SRC)) begin
         w1_cur = 13'(eqc_pkg::MAX_SRC - 1);
      end else begin
         w1_cur = 13'(source_width_ff - 14'd1);
      end
      if (source_height_ff == '0) begin
         h1_cur = '0;
      end else if (source_height_ff > 14'(eqc_pkg::MAX_SRC)) begin
         h1_cur = 13'(eqc_pkg::MAX_SRC - 1);
      end else begin
         h1_cur = 13'(source_height_ff - 14'd1);
      end
   end

   // handshake chain
   assign adv[NS-1] = !valid_ff[NS-1] || rsp_ready;
   for (genvar k = 0; k < NS - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign req_ready = adv[0];

   assign valid_in[0] = req_valid;
   for (genvar k = 1; k < NS; k++) begin : g_valid
      assign valid_in[k] = valid_ff[k-1];
   end

   always_comb begin
      lane_in[0]      = '0;
      lane_in[0].face = req_face_index;
      lane_in[0].row  = req_pixel_row;
      lane_in[0].col  = req_pixel_col;
   end

   for (genvar k = 1; k < NS; k++) begin : g_stage
      always_comb begin
         eqc_pkg::lane_type    a;
         eqc_pkg::lane_type    r;
         logic signed [14:0]   nn;
         logic signed [14:0]   tr;
         logic signed [14:0]   tc;
         logic signed [13:0]   pxv;
         logic signed [13:0]   pyv;
         logic signed [CW-1:0] sn;
         logic signed [CW-1:0] ox;
         logic signed [CW-1:0] oy;
         logic [12:0]          pabs;
         logic [60:0]          gsum;
         logic signed [CW-1:0] gpos;
         logic signed [ZW-1:0] zz;
         logic signed [ZW-1:0] azim;
         logic [46:0]          xsum;
         logic [46:0]          xsh;
         logic [45:0]          ysum;
         logic [45:0]          ysh;
         a    = lane_ff[k-1];
         r    = a;
         nn   = $signed({2'b00, n_cur});
         tr   = $signed({2'b00, a.row, 1'b0});
         tc   = $signed({2'b00, a.col, 1'b0});
         pxv  = '0;
         pyv  = '0;
         sn   = $signed(CW'({n_cur, 16'h0000}));
         ox   = '0;
         oy   = '0;
         pabs = '0;
         gsum = '0;
         gpos = '0;
         zz   = '0;
         azim = '0;
         xsum = '0;
         xsh  = '0;
         ysum = '0;
         ysh  = '0;
         if (k == eqc_pkg::ST_CLAMP) begin
            if (a.face > eqc_pkg::FACE_BOTTOM) begin
               r.face = '0;
            end
            if ({1'b0, a.row} >= n_cur) begin
               r.row = 12'(n_cur - 13'd1);
            end
            if ({1'b0, a.col} >= n_cur) begin
               r.col = 12'(n_cur - 13'd1);
            end
         end
         if (k == eqc_pkg::ST_PREP) begin
            if (a.face == eqc_pkg::FACE_TOP) begin
               pxv = 14'(tr - nn);
               pyv = 14'(nn - 15'sd2 - tc);
            end else if (a.face == eqc_pkg::FACE_BOTTOM) begin
               pxv = 14'(nn - 15'sd2 - tr);
               pyv = 14'(tc - nn);
            end else begin
               pxv = 14'(tc - nn);
               pyv = 14'(tr - nn);
            end
            r.px = pxv;
            r.py = pyv;
            if (a.face == eqc_pkg::FACE_TOP) begin
               ox = CW'(pxv) <<< eqc_pkg::SCALE_SHIFT;
               oy = -(CW'(pyv) <<< eqc_pkg::SCALE_SHIFT);
            end else if (a.face == eqc_pkg::FACE_BOTTOM) begin
               ox = CW'(pxv) <<< eqc_pkg::SCALE_SHIFT;
               oy = CW'(pyv) <<< eqc_pkg::SCALE_SHIFT;
            end else begin
               ox = sn;
               oy = CW'(pxv) <<< eqc_pkg::SCALE_SHIFT;
            end
            r.ox_neg   = ox < 0;
            r.ox_zero  = ox == 0;
            r.oy_zero  = oy == 0;
            r.oy_pos   = oy > 0;
            r.top_seam = (a.face == eqc_pkg::FACE_TOP) && (pyv == 0) && (pxv < 0);
            if (ox < 0) begin
               r.x = -ox;
               r.y = -oy;
               r.z = (oy >= 0) ? eqc_pkg::ANG_PI : -eqc_pkg::ANG_PI;
            end else begin
               r.x = ox;
               r.y = oy;
               r.z = '0;
            end
            if (a.face == eqc_pkg::FACE_TOP || a.face == eqc_pkg::FACE_BOTTOM) begin
               r.gm   = 29'({n_cur, 16'h0000});
               r.gneg = 1'b0;
            end else begin
               pabs   = (pyv < 0) ? 13'(-pyv) : 13'(pyv);
               r.gm   = 29'({pabs, 16'h0000});
               r.gneg = pyv < 0;
            end
         end
         if (k >= eqc_pkg::ST_C1 && k < eqc_pkg::ST_MID) begin
            r = cordic_iter(a, 5'(k - eqc_pkg::ST_C1));
         end
         if (k >= eqc_pkg::ST_C2 && k < eqc_pkg::ST_ANGLE) begin
            r = cordic_iter(a, 5'(k - eqc_pkg::ST_C2));
         end
         if (k == eqc_pkg::ST_C1) begin
            r.gprod = 60'(a.gm) * 60'(eqc_pkg::GAIN_Q30);
         end
         if (k == eqc_pkg::ST_C1 + 1) begin
            gsum = 61'(a.gprod) + (61'd1 << 29);
            gpos = $signed(CW'(30'(gsum >> 30)));
            r.gy = a.gneg ? -gpos : gpos;
         end
         if (k == eqc_pkg::ST_MID) begin
            zz = fix_angle(a);
            unique case (a.face[1:0])
               2'd0:    azim = '0;
               2'd1:    azim = eqc_pkg::ANG_HALF_PI;
               2'd2:    azim = eqc_pkg::ANG_PI;
               default: azim = -eqc_pkg::ANG_HALF_PI;
            endcase
            if (a.face < eqc_pkg::FACE_TOP) begin
               r.u = zz + azim;
            end else if (a.top_seam) begin
               r.u = -eqc_pkg::ANG_PI;
            end else begin
               r.u = zz;
            end
            r.x       = a.x;
            r.y       = a.gy;
            r.z       = '0;
            r.ox_neg  = a.x < 0;
            r.ox_zero = a.x == 0;
            r.oy_zero = a.gy == 0;
            r.oy_pos  = a.gy > 0;
         end
         if (k == eqc_pkg::ST_C2) begin
            if (a.u > eqc_pkg::ANG_PI) begin
               r.u = a.u - (eqc_pkg::ANG_PI <<< 1);
            end else if (a.u < -eqc_pkg::ANG_PI) begin
               r.u = a.u + (eqc_pkg::ANG_PI <<< 1);
            end
         end
         if (k == eqc_pkg::ST_ANGLE) begin
            zz = fix_angle(a);
            if (a.face == eqc_pkg::FACE_TOP) begin
               zz = -zz;
            end
            if (zz > eqc_pkg::ANG_HALF_PI) begin
               zz = eqc_pkg::ANG_HALF_PI;
            end else if (zz < -eqc_pkg::ANG_HALF_PI) begin
               zz = -eqc_pkg::ANG_HALF_PI;
            end
            r.tv = 32'(zz + eqc_pkg::ANG_HALF_PI);
            r.tu = 33'(a.u + eqc_pkg::ANG_PI);
         end
         if (k == eqc_pkg::ST_MUL) begin
            r.xprod = a.tu * 46'(w1_cur);
            r.yprod = a.tv * 45'(h1_cur);
         end
         if (k == eqc_pkg::ST_OUT) begin
            xsum = 47'(a.xprod) + (47'd1 << (XS - 1));
            xsh  = xsum >> XS;
            ysum = 46'(a.yprod) + (46'd1 << (YS - 1));
            ysh  = ysum >> YS;
            r.sx = (xsh > 47'(eqc_pkg::OUT_MAX)) ? eqc_pkg::OUT_MAX : 21'(xsh);
            r.sy = (ysh > 46'(eqc_pkg::OUT_MAX)) ? eqc_pkg::OUT_MAX : 21'(ysh);
         end
         lane_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            lane_ff[k] <= lane_in[k];
         end
      end
   end

   assign rsp_valid    = valid_ff[NS-1];
   assign rsp_source_x = lane_ff[NS-1].sx;
   assign rsp_source_y = lane_ff[NS-1].sy;

   // checks
   a_row_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[eqc_pkg::ST_CLAMP] |->
         ({1'b0, lane_ff[eqc_pkg::ST_CLAMP].row} < n_cur &&
          {1'b0, lane_ff[eqc_pkg::ST_CLAMP].col} < n_cur))
      else $error("clamped pixel outside face");

   a_mag_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff[eqc_pkg::ST_MID] |-> lane_ff[eqc_pkg::ST_MID].x >= 0)
      else $error("negative cordic magnitude");

   a_azimuth_wrapped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[eqc_pkg::ST_C2] |->
         (lane_ff[eqc_pkg::ST_C2].u <= eqc_pkg::ANG_PI &&
          lane_ff[eqc_pkg::ST_C2].u >= -eqc_pkg::ANG_PI))
      else $error("azimuth out of range after wrap");

endmodule
`default_nettype wire
